[rtl/synced_code_pattern_transmitter_assert.svh]
// Assertion macros used by the checker file.
`ifndef SYNCED_CODE_PATTERN_TRANSMITTER_ASSERT_SVH
`define SYNCED_CODE_PATTERN_TRANSMITTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SCPT_ASSERT_IMP(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("scpt assertion failed");

// Next-cycle implication, disabled during reset.
`define SCPT_ASSERT_NXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("scpt assertion failed");

`endif

[rtl/scpt_pkg.sv]
package scpt_pkg;

   // Transmit-off bits of the output port.
   localparam logic [15:0] OFF_BITS = 16'h0300;

   // Request opcodes.
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;

   // Register indexes on the csr port.
   localparam logic [1:0] CSR_CODE_LENGTH = 2'd0;
   localparam logic [1:0] CSR_REPEAT      = 2'd1;
   localparam logic [1:0] CSR_CYCLES      = 2'd2;
   localparam logic [1:0] CSR_SYNC        = 2'd3;

   // Sync sources; anything at or above SYNC_NONE skips the wait.
   localparam logic [1:0] SYNC_ATOMIC = 2'd0;
   localparam logic [1:0] SYNC_GPS    = 2'd1;
   localparam logic [1:0] SYNC_NONE   = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  table_index;
      logic [15:0] table_word;
      logic        clock_pulse_level;
      logic        gps_pulse_level;
      logic        carrier_level;
   } req_type;

   typedef struct packed {
      logic [15:0] port_value;
      logic        busy_res;
      logic        epoch_mark;
      logic        done_res;
   } rsp_type;

   // Table write and read requests.
   typedef struct packed {
      logic        en;
      logic [7:0]  addr;
      logic [15:0] data;
   } tbl_wr_type;

   typedef struct packed {
      logic        en;
      logic [8:0]  addr;
   } tbl_rd_type;

endpackage

[rtl/scpt_table.sv]
module scpt_table
   import scpt_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  tbl_wr_type  wr,
   input  tbl_rd_type  rd,
   output logic [15:0] rd_data
);

   localparam int AW = $clog2(TABLE_DEPTH);

   logic [15:0] mem [TABLE_DEPTH];
   logic [31:0] wr_idx;
   logic [31:0] rd_idx;
   logic        wr_hit;
   logic        rd_hit;
   logic [15:0] rd_data_ff;
   logic        rd_hit_ff;

   assign wr_idx = 32'(wr.addr);
   assign rd_idx = 32'(rd.addr);
   assign wr_hit = wr_idx < 32'(TABLE_DEPTH);
   assign rd_hit = rd_idx < 32'(TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (wr.en && wr_hit) begin
         mem[wr_idx[AW-1:0]] <= wr.data;
      end
   end

   // Read data held until the next read; out-of-range reads give zero.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_hit_ff <= rd_hit;
         if (rd_hit) begin
            rd_data_ff <= mem[rd_idx[AW-1:0]];
         end
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : 16'h0000;

endmodule

[rtl/synced_code_pattern_transmitter.sv]
// channel  | direction | handshake           | payload
// req      | in        | req_valid/req_stall | req_data  (req_type)
// rsp      | out       | rsp_valid/rsp_stall | rsp_data  (rsp_type)
// csr      | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One word accepted per cycle while req_stall is low; its result word leaves
// via stage 1 (the code table's registered read port) and the output register.
// Sequencer state updates at acceptance; only the port value waits on the table.
// Synchronous reset clears sequencer and port (0x0300); the table is not cleared.
// rsp_stall freezes the output register; stage 1 takes one more word, then
// req_stall rises until the output drains.
module synced_code_pattern_transmitter
   import scpt_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   // Sequencer phases.
   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_SYNC_LOW  = 3'd1;
   localparam logic [2:0] PH_SYNC_HIGH = 3'd2;
   localparam logic [2:0] PH_SEND      = 3'd3;
   localparam logic [2:0] PH_FINISH    = 3'd4;

   // What stage 2 does to the port register.
   localparam logic [1:0] ACT_KEEP = 2'd0;
   localparam logic [1:0] ACT_OFF  = 2'd1;
   localparam logic [1:0] ACT_LOAD = 2'd2;

   // Config registers. The user must write them only with no word in flight,
   // unenforced; ready is tied high; a mid-run change applies to the next word.
   logic [7:0]  cfg_code_length_ff;
   logic [15:0] cfg_repeat_ff;
   logic [7:0]  cfg_cycles_ff;
   logic [1:0]  cfg_sync_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_code_length_ff <= '0;
         cfg_repeat_ff      <= '0;
         cfg_cycles_ff      <= '0;
         cfg_sync_ff        <= SYNC_ATOMIC;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CODE_LENGTH: cfg_code_length_ff <= csr_data[7:0];
            CSR_REPEAT:      cfg_repeat_ff      <= csr_data;
            CSR_CYCLES:      cfg_cycles_ff      <= csr_data[7:0];
            CSR_SYNC:        cfg_sync_ff        <= csr_data[1:0];
            default:         ;
         endcase
      end
   end

   // Sequencer state.
   logic [2:0]  phase_ff, phase_in;
   logic [15:0] rep_ff, rep_in;
   logic [7:0]  elem_ff, elem_in;
   logic [7:0]  cyc_ff, cyc_in;
   logic        half_ff, half_in;
   logic        seen_ff, seen_in;

   // Stage 1: table read in flight.
   logic        s1_valid_ff;
   logic [1:0]  s1_act_ff, s1_act_in;
   logic        s1_busy_ff;
   logic        s1_epoch_ff, s1_epoch_in;
   logic        s1_done_ff, s1_done_in;

   // Stage 2: port register and output word.
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   logic [15:0] port_ff, port_in;

   logic        out_free;
   logic        s1_adv;
   logic        req_accept;
   logic        no_sync;
   logic        pps;
   logic        zero_count;
   logic [8:0]  cyc_nxt;
   logic [8:0]  elem_nxt;
   logic [16:0] rep_nxt;
   tbl_wr_type  tbl_wr;
   tbl_rd_type  tbl_rd;
   logic [15:0] tbl_data;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign no_sync    = cfg_sync_ff >= SYNC_NONE;
   assign pps        = (cfg_sync_ff == SYNC_GPS) ? req_data.gps_pulse_level
                                                 : req_data.clock_pulse_level;
   assign zero_count = (cfg_code_length_ff == 8'd0) || (cfg_repeat_ff == 16'd0)
                    || (cfg_cycles_ff == 8'd0);
   assign cyc_nxt    = {1'b0, cyc_ff} + 9'd1;
   assign elem_nxt   = {1'b0, elem_ff} + 9'd1;
   assign rep_nxt    = {1'b0, rep_ff} + 17'd1;

   always_comb begin
      phase_in    = phase_ff;
      rep_in      = rep_ff;
      elem_in     = elem_ff;
      cyc_in      = cyc_ff;
      half_in     = half_ff;
      seen_in     = seen_ff;
      s1_act_in   = ACT_KEEP;
      s1_epoch_in = 1'b0;
      s1_done_in  = 1'b0;
      tbl_wr.en   = 1'b0;
      tbl_wr.addr = req_data.table_index;
      tbl_wr.data = req_data.table_word;
      tbl_rd.en   = 1'b0;
      tbl_rd.addr = {elem_ff, half_ff};

      // Epoch: clear counters and enter send, or go straight to finish.
      unique case (req_data.opcode)
         OP_WRITE: begin
            tbl_wr.en = 1'b1;
         end
         OP_START: begin
            if (phase_ff == PH_IDLE) begin
               s1_act_in = ACT_OFF;
               if (no_sync) begin
                  s1_epoch_in = 1'b1;
               end else begin
                  phase_in = PH_SYNC_LOW;
               end
            end
         end
         OP_TICK: begin
            unique case (phase_ff)
               PH_SYNC_LOW: begin
                  if (no_sync) begin
                     s1_epoch_in = 1'b1;
                  end else if (!pps) begin
                     phase_in = PH_SYNC_HIGH;
                  end
               end
               PH_SYNC_HIGH: begin
                  if (no_sync || pps) begin
                     s1_epoch_in = 1'b1;
                  end
               end
               PH_SEND: begin
                  if (!seen_ff) begin
                     seen_in = req_data.carrier_level;
                  end else if (!req_data.carrier_level) begin
                     // Falling carrier edge: fetch the next half of the element.
                     seen_in   = 1'b0;
                     s1_act_in = ACT_LOAD;
                     tbl_rd.en = 1'b1;
                     if (!half_ff) begin
                        half_in = 1'b1;
                     end else begin
                        half_in = 1'b0;
                        if (cyc_nxt < {1'b0, cfg_cycles_ff}) begin
                           cyc_in = cyc_nxt[7:0];
                        end else begin
                           cyc_in = '0;
                           if (elem_nxt < {1'b0, cfg_code_length_ff}) begin
                              elem_in = elem_nxt[7:0];
                           end else begin
                              elem_in = '0;
                              if (rep_nxt < {1'b0, cfg_repeat_ff}) begin
                                 rep_in = rep_nxt[15:0];
                              end else begin
                                 rep_in   = '0;
                                 phase_in = PH_FINISH;
                              end
                           end
                        end
                     end
                  end
               end
               PH_FINISH: begin
                  if (!req_data.carrier_level) begin
                     s1_act_in  = ACT_OFF;
                     s1_done_in = 1'b1;
                     phase_in   = PH_IDLE;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase

      if (s1_epoch_in) begin
         rep_in   = '0;
         elem_in  = '0;
         cyc_in   = '0;
         half_in  = 1'b0;
         seen_in  = 1'b0;
         phase_in = zero_count ? PH_FINISH : PH_SEND;
      end
   end

   // Write then read of one entry lands on separate edges, so no bypass.
   scpt_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr      (req_accept ? tbl_wr : '0),
      .rd      (req_accept ? tbl_rd : '0),
      .rd_data (tbl_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         rep_ff   <= '0;
         elem_ff  <= '0;
         cyc_ff   <= '0;
         half_ff  <= 1'b0;
         seen_ff  <= 1'b0;
      end else if (req_accept) begin
         phase_ff <= phase_in;
         rep_ff   <= rep_in;
         elem_ff  <= elem_in;
         cyc_ff   <= cyc_in;
         half_ff  <= half_in;
         seen_ff  <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_act_ff   <= s1_act_in;
         s1_busy_ff  <= phase_in != PH_IDLE;
         s1_epoch_ff <= s1_epoch_in;
         s1_done_ff  <= s1_done_in;
      end
   end

   // Port register is owned by stage 2 alone, so updates stay in order.
   always_comb begin
      unique case (s1_act_ff)
         ACT_OFF:  port_in = port_ff | OFF_BITS;
         ACT_LOAD: port_in = tbl_data;
         default:  port_in = port_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         port_ff      <= OFF_BITS;
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         port_ff      <= port_in;
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff.port_value <= port_in;
         rsp_data_ff.busy_res   <= s1_busy_ff;
         rsp_data_ff.epoch_mark <= s1_epoch_ff;
         rsp_data_ff.done_res   <= s1_done_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/scpt_checker.sv]
`include "synced_code_pattern_transmitter_assert.svh"

module scpt_checker
   import scpt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // Held output word stays put.
   `SCPT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // Input backpressure only comes from a blocked output.
   `SCPT_ASSERT_IMP(a_stall_cause, clock, reset, req_valid && req_stall, rsp_valid && rsp_stall)

   // Epoch and done never share a word.
   `SCPT_ASSERT_IMP(a_epoch_done, clock, reset, rsp_valid, !(rsp_data.epoch_mark && rsp_data.done_res))

   // Epoch starts a run; done ends it with the port off.
   `SCPT_ASSERT_IMP(a_epoch_busy, clock, reset, rsp_valid && rsp_data.epoch_mark, rsp_data.busy_res)

   `SCPT_ASSERT_IMP(a_done_off, clock, reset, rsp_valid && rsp_data.done_res, !rsp_data.busy_res && ((rsp_data.port_value & OFF_BITS) == OFF_BITS))

endmodule

bind synced_code_pattern_transmitter scpt_checker u_scpt_checker (.*);
